// ----- hdl/pkt_dfr_pkg.sv -----
`default_nettype none

package pkt_dfr_pkg;

    // Frame layout: three header bytes, the payload, then the sum and check bytes.
    localparam int unsigned HDR_BYTES  = 3;
    localparam int unsigned TAIL_BYTES = 2;
    localparam int unsigned POS_W      = 17;
    localparam int unsigned LEN_W      = 16;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Status reported with the final byte of a frame.
    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_HDR = 2'd2,
        ST_SUM = 2'd3
    } status_t;

    // One result item as it travels through the output stage.
    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             frame_done;
        status_t          frame_status;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       packet_number;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/packet_deframer_sum8_check.sv -----
// Deframer for length-prefixed frames that carry an 8-bit payload sum.
// Input channel: one frame byte per item (rx_byte), with end_of_frame set on
// the final byte. An item is taken when in_valid is high and in_stall is low.
// Output channel: a result item for every payload byte and for every final
// byte. Payload bytes are passed on as they arrive; the final byte's item
// carries frame_done, frame_status, payload_length and packet_number.
// A payload byte that is also the final byte shares one item with the status.
// Header and trailer bytes produce no item unless they are the final byte.
// One item is accepted in every cycle while in_stall is low; the decode is a
// single step of compares and an 8-bit add between the frame state registers
// and the output register.
// A two-entry output stage (output register plus skid register) lets the block
// take one more item while a result waits on out_stall. in_stall rises only
// when both entries are full, and it is driven from a register.
// Reset clears the frame position and all frame state; no output item is held.
`default_nettype none

module packet_deframer_sum8_check
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 end_of_frame,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      payload_valid,
    output logic [7:0]                payload_byte,
    output logic                      frame_done,
    output pkt_dfr_pkg::status_t      frame_status,
    output logic [15:0]               payload_length,
    output logic [7:0]                packet_number
);
    import pkt_dfr_pkg::*;

    logic [POS_W-1:0] byte_position_reg;
    logic [POS_W-1:0] byte_position_next;
    logic [LEN_W-1:0] header_length_reg;
    logic [LEN_W-1:0] header_length_next;
    logic [7:0]       seq_number_reg;
    logic [7:0]       seq_number_next;
    logic [7:0]       running_sum_reg;
    logic [7:0]       running_sum_next;
    logic [7:0]       received_sum_reg;
    logic [7:0]       received_sum_next;

    result_t          out_data_reg;
    result_t          skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic             accept;
    logic             has_result;
    logic [POS_W-1:0] sum_pos;
    logic [POS_W-1:0] end_pos;
    logic [7:0]       header_xor;
    result_t          res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    // Decode one byte against the frame state.
    always_comb
    begin
        header_length_next = header_length_reg;
        seq_number_next    = seq_number_reg;
        running_sum_next   = running_sum_reg;
        received_sum_next  = received_sum_reg;
        res                = '0;
        sum_pos            = POS_W'(HDR_BYTES) + {1'b0, header_length_reg};

        if (byte_position_reg == POS_W'(0))
        begin
            header_length_next = {rx_byte, 8'h00};
        end
        else if (byte_position_reg == POS_W'(1))
        begin
            header_length_next = {header_length_reg[15:8], rx_byte};
        end
        else if (byte_position_reg == POS_W'(2))
        begin
            seq_number_next = rx_byte;
        end
        else if (byte_position_reg < sum_pos)
        begin
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
            running_sum_next  = running_sum_reg + rx_byte;
        end
        else if (byte_position_reg == sum_pos)
        begin
            received_sum_next = rx_byte;
        end

        // Checks on the final byte use the state as updated by this byte.
        end_pos    = POS_W'(HDR_BYTES + TAIL_BYTES - 1) + {1'b0, header_length_next};
        header_xor = header_length_next[15:8] ^ header_length_next[7:0] ^ seq_number_next;

        if (end_of_frame)
        begin
            res.frame_done = 1'b1;
            if (byte_position_reg != end_pos)
            begin
                res.frame_status = ST_LEN;
            end
            else if (rx_byte != header_xor)
            begin
                res.frame_status = ST_HDR;
            end
            else if (running_sum_next != received_sum_next)
            begin
                res.frame_status  = ST_SUM;
                res.packet_number = seq_number_next;
            end
            else
            begin
                res.frame_status   = ST_OK;
                res.packet_number  = seq_number_next;
                res.payload_length = header_length_next;
            end
        end

        has_result = res.payload_valid || res.frame_done;

        // The position saturates on long frames and restarts after the final byte.
        if (end_of_frame)
        begin
            byte_position_next = '0;
        end
        else if (byte_position_reg < POS_MAX)
        begin
            byte_position_next = byte_position_reg + POS_W'(1);
        end
        else
        begin
            byte_position_next = byte_position_reg;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            header_length_reg <= '0;
            seq_number_reg    <= '0;
            running_sum_reg   <= '0;
            received_sum_reg  <= '0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            if (end_of_frame)
            begin
                header_length_reg <= '0;
                seq_number_reg    <= '0;
                running_sum_reg   <= '0;
                received_sum_reg  <= '0;
            end
            else
            begin
                header_length_reg <= header_length_next;
                seq_number_reg    <= seq_number_next;
                running_sum_reg   <= running_sum_next;
                received_sum_reg  <= received_sum_next;
            end
        end
    end

    // Output stage control: output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept && has_result;
            end
        end
        else if (accept && has_result)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage data.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept && has_result)
            begin
                out_data_reg <= res;
            end
        end
        else if (accept && has_result)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_valid  = out_data_reg.payload_valid;
    assign payload_byte   = out_data_reg.payload_byte;
    assign frame_done     = out_data_reg.frame_done;
    assign frame_status   = out_data_reg.frame_status;
    assign payload_length = out_data_reg.payload_length;
    assign packet_number  = out_data_reg.packet_number;

    // The skid entry is only used while the output register is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    // Every delivered item carries a payload byte or a frame status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.payload_valid || out_data_reg.frame_done))
        else $error("output item with neither payload nor status");

    // A payload byte that ends the frame always reports a length mismatch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.payload_valid && out_data_reg.frame_done)
        |-> (out_data_reg.frame_status == ST_LEN))
        else $error("payload byte on final byte without length mismatch");

    // The frame position restarts after a final byte is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_frame) |=> (byte_position_reg == '0))
        else $error("frame position not cleared after final byte");

endmodule

`default_nettype wire
